// ===== rtl/pfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette framebuffer controller package
// Shared constants, codes and the operation record passed from the front end
// to the back end.
// ----------------------------------------------------------------------------
package pfc_pkg;

  localparam int PALETTE_DEPTH = 256;
  localparam int PAL_IDX_W     = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CTRL_BYTES    = 16;
  localparam int WINDOW_BYTES  = CTRL_BYTES + 4 * PALETTE_DEPTH;
  localparam int OPQ_DEPTH     = 2;
  localparam int OPQ_PTR_W     = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int OPQ_CNT_W     = $clog2(OPQ_DEPTH + 1);

  localparam logic [31:0] MODE_GREY    = 32'd0;
  localparam logic [31:0] MODE_INDEXED = 32'd1;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [3:0]  WORD_BYTES   = 4'd4;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_PIXEL = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CTRL_ENABLE = 2'd0,
    CTRL_MODE   = 2'd1,
    CTRL_WIDTH  = 2'd2,
    CTRL_HEIGHT = 2'd3
  } ctrl_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ERROR,
    OP_CTRL_RD,
    OP_CTRL_WR,
    OP_PAL_RD,
    OP_PAL_WR,
    OP_PIXEL
  } op_e;

  typedef enum logic [1:0] {
    MCLS_GREY,
    MCLS_INDEXED,
    MCLS_RAW
  } mode_cls_e;

  typedef struct packed {
    op_e                  kind;
    ctrl_e                ctrl;
    logic [PAL_IDX_W-1:0] idx;
    logic                 pix_ok;
    logic [31:0]          data;
  } op_t;

endpackage

// ===== rtl/pfc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette framebuffer controller front end
// Holds the window base, tests each item against the register window and
// turns it into an operation record.
// ----------------------------------------------------------------------------
module pfc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic [1:0]         command_i,
  input  logic [31:0]        bus_address_i,
  input  logic [3:0]         access_size_i,
  input  logic [31:0]        write_data_i,
  input  logic [31:0]        pixel_word_i,
  output pfc_pkg::op_t       op_o
);

  logic [31:0] base_q, base_d;
  logic [32:0] limit_q, limit_d;
  logic [32:0] addr_end;
  logic [31:0] off;
  logic [29:0] pal_word;
  logic        in_win;
  logic        aligned;
  logic        is_ctrl;
  logic        is_wr;

  assign base_d  = cfg_wdata_i;
  assign limit_d = {1'b0, cfg_wdata_i} + 33'(pfc_pkg::WINDOW_BYTES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      limit_q <= 33'(pfc_pkg::WINDOW_BYTES);
    end else if (cfg_we_i) begin
      base_q  <= base_d;
      limit_q <= limit_d;
    end
  end

  assign addr_end = {1'b0, bus_address_i} + {29'd0, access_size_i};
  assign in_win   = (bus_address_i >= base_q) && (addr_end <= limit_q);
  assign off      = bus_address_i - base_q;
  assign aligned  = (access_size_i == pfc_pkg::WORD_BYTES) && (bus_address_i[1:0] == 2'b00);
  assign is_ctrl  = (off[31:4] == 28'd0);
  assign pal_word = off[31:2] - 30'd4;
  assign is_wr    = (command_i == pfc_pkg::CMD_WRITE);

  always_comb begin
    op_o        = '0;
    op_o.kind   = pfc_pkg::OP_NONE;
    op_o.ctrl   = pfc_pkg::ctrl_e'(off[3:2]);
    op_o.idx    = pal_word[pfc_pkg::PAL_IDX_W-1:0];
    op_o.pix_ok = 1'b0;
    op_o.data   = write_data_i;
    unique case (command_i)
      pfc_pkg::CMD_READ, pfc_pkg::CMD_WRITE: begin
        if (in_win) begin
          if (!aligned) begin
            op_o.kind = pfc_pkg::OP_ERROR;
          end else if (is_ctrl) begin
            op_o.kind = is_wr ? pfc_pkg::OP_CTRL_WR : pfc_pkg::OP_CTRL_RD;
          end else begin
            op_o.kind = is_wr ? pfc_pkg::OP_PAL_WR : pfc_pkg::OP_PAL_RD;
          end
        end
      end
      pfc_pkg::CMD_PIXEL: begin
        op_o.kind   = pfc_pkg::OP_PIXEL;
        op_o.data   = pixel_word_i;
        op_o.idx    = pixel_word_i[pfc_pkg::PAL_IDX_W-1:0];
        op_o.pix_ok = ({1'b0, pixel_word_i[7:0]} < 9'(pfc_pkg::PALETTE_DEPTH));
      end
      default: begin
        op_o.kind = pfc_pkg::OP_NONE;
      end
    endcase
  end

endmodule

// ===== rtl/pfc_opq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette framebuffer controller operation queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module pfc_opq (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  pfc_pkg::op_t wdata_i,
  output logic         full_o,
  input  logic         rd_i,
  output logic         vld_o,
  output pfc_pkg::op_t rdata_o
);

  pfc_pkg::op_t                  store_q [pfc_pkg::OPQ_DEPTH];
  logic [pfc_pkg::OPQ_PTR_W-1:0] wptr_q, wptr_d;
  logic [pfc_pkg::OPQ_PTR_W-1:0] rptr_q, rptr_d;
  logic [pfc_pkg::OPQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                          do_wr, do_rd;

  assign full_o  = (cnt_q == pfc_pkg::OPQ_CNT_W'(pfc_pkg::OPQ_DEPTH));
  assign vld_o   = (cnt_q != '0);
  assign rdata_o = store_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && vld_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_wr) begin
      wptr_d = (wptr_q == pfc_pkg::OPQ_PTR_W'(pfc_pkg::OPQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == pfc_pkg::OPQ_PTR_W'(pfc_pkg::OPQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      store_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/pfc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette framebuffer controller back end
// Holds the control registers and the palette, carries out each operation
// and keeps the finished item in an output register.
// ----------------------------------------------------------------------------
module pfc_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         op_vld_i,
  input  pfc_pkg::op_t op_i,
  output logic         take_o,
  input  logic         pop,
  output logic         empty,
  output logic         handled_o,
  output logic         access_error_o,
  output logic [31:0]  read_data_o,
  output logic [31:0]  pixel_color_o
);

  logic [31:0] pal_mem [pfc_pkg::PALETTE_DEPTH];
  logic [pfc_pkg::PALETTE_DEPTH-1:0] pal_vld_q;

  logic [31:0] enable_q, mode_q, width_q, height_q;

  logic                s1_vld_q;
  pfc_pkg::op_e        s1_kind_q;
  logic [31:0]         s1_data_q;
  logic                s1_pix_ok_q;
  logic [31:0]         s1_ctrl_q;
  pfc_pkg::mode_cls_e  s1_mcls_q;
  logic [31:0]         s1_pal_q;
  logic                s1_pal_vld_q;

  logic        out_vld_q;
  logic        out_handled_q, out_err_q;
  logic [31:0] out_rdata_q, out_color_q;

  logic               out_free, s1_adv, take;
  logic [31:0]        ctrl_rd;
  pfc_pkg::mode_cls_e mcls;
  logic [31:0]        pal_val;
  logic               res_handled, res_err;
  logic [31:0]        res_rdata, res_color;

  assign out_free = !out_vld_q || pop;
  assign s1_adv   = s1_vld_q && out_free;
  assign take     = op_vld_i && (!s1_vld_q || out_free);
  assign take_o   = take;

  always_comb begin
    unique case (op_i.ctrl)
      pfc_pkg::CTRL_ENABLE: ctrl_rd = enable_q;
      pfc_pkg::CTRL_MODE:   ctrl_rd = mode_q;
      pfc_pkg::CTRL_WIDTH:  ctrl_rd = width_q;
      pfc_pkg::CTRL_HEIGHT: ctrl_rd = height_q;
      default:              ctrl_rd = '0;
    endcase
  end

  always_comb begin
    if (mode_q == pfc_pkg::MODE_GREY) begin
      mcls = pfc_pkg::MCLS_GREY;
    end else if (mode_q == pfc_pkg::MODE_INDEXED) begin
      mcls = pfc_pkg::MCLS_INDEXED;
    end else begin
      mcls = pfc_pkg::MCLS_RAW;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= '0;
      mode_q    <= '0;
      width_q   <= '0;
      height_q  <= '0;
      pal_vld_q <= '0;
    end else if (take) begin
      if (op_i.kind == pfc_pkg::OP_CTRL_WR) begin
        unique case (op_i.ctrl)
          pfc_pkg::CTRL_ENABLE: enable_q <= op_i.data;
          pfc_pkg::CTRL_MODE:   mode_q   <= op_i.data;
          pfc_pkg::CTRL_WIDTH:  width_q  <= op_i.data;
          pfc_pkg::CTRL_HEIGHT: height_q <= op_i.data;
          default:              enable_q <= enable_q;
        endcase
      end
      if (op_i.kind == pfc_pkg::OP_PAL_WR) begin
        pal_vld_q[op_i.idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      if (op_i.kind == pfc_pkg::OP_PAL_WR) begin
        pal_mem[op_i.idx] <= op_i.data;
      end
      s1_pal_q <= pal_mem[op_i.idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (take) begin
      s1_vld_q <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_kind_q    <= op_i.kind;
      s1_data_q    <= op_i.data;
      s1_pix_ok_q  <= op_i.pix_ok;
      s1_ctrl_q    <= ctrl_rd;
      s1_mcls_q    <= mcls;
      s1_pal_vld_q <= pal_vld_q[op_i.idx];
    end
  end

  assign pal_val = s1_pal_vld_q ? s1_pal_q : '0;

  always_comb begin
    res_handled = 1'b0;
    res_err     = 1'b0;
    res_rdata   = '0;
    res_color   = '0;
    unique case (s1_kind_q)
      pfc_pkg::OP_NONE: begin
        res_handled = 1'b0;
      end
      pfc_pkg::OP_ERROR: begin
        res_handled = 1'b1;
        res_err     = 1'b1;
      end
      pfc_pkg::OP_CTRL_RD: begin
        res_handled = 1'b1;
        res_rdata   = s1_ctrl_q;
      end
      pfc_pkg::OP_PAL_RD: begin
        res_handled = 1'b1;
        res_rdata   = pal_val;
      end
      pfc_pkg::OP_CTRL_WR, pfc_pkg::OP_PAL_WR: begin
        res_handled = 1'b1;
      end
      pfc_pkg::OP_PIXEL: begin
        unique case (s1_mcls_q)
          pfc_pkg::MCLS_GREY:
            res_color = {s1_data_q[7:0], s1_data_q[7:0], s1_data_q[7:0], pfc_pkg::ALPHA_OPAQUE};
          pfc_pkg::MCLS_INDEXED:
            res_color = s1_pix_ok_q ? pal_val : '0;
          default:
            res_color = s1_data_q;
        endcase
      end
      default: begin
        res_handled = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_handled_q <= res_handled;
      out_err_q     <= res_err;
      out_rdata_q   <= res_rdata;
      out_color_q   <= res_color;
    end
  end

  assign empty          = !out_vld_q;
  assign handled_o      = out_handled_q;
  assign access_error_o = out_err_q;
  assign read_data_o    = out_rdata_q;
  assign pixel_color_o  = out_color_q;

endmodule

// ===== rtl/palette_framebuffer_controller_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette framebuffer controller core
// Path: operation queue, back-end stage register, then the output register.
// Throughput: one item per cycle while pop is held high; push stalls when full.
// Reset: window base, control words and palette valid bits clear at once;
// palette entries never written read as zero. No clearing pass.
// ----------------------------------------------------------------------------
module palette_framebuffer_controller_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [31:0] bus_address_i,
  input  logic [3:0]  access_size_i,
  input  logic [31:0] write_data_i,
  input  logic [31:0] pixel_word_i,
  output logic        empty,
  input  logic        pop,
  output logic        handled_o,
  output logic        access_error_o,
  output logic [31:0] read_data_o,
  output logic [31:0] pixel_color_o
);

  pfc_pkg::op_t front_op, q_op;
  logic         q_vld, q_take;

  pfc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .command_i     (command_i),
    .bus_address_i (bus_address_i),
    .access_size_i (access_size_i),
    .write_data_i  (write_data_i),
    .pixel_word_i  (pixel_word_i),
    .op_o          (front_op)
  );

  pfc_opq u_opq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .wdata_i (front_op),
    .full_o  (full),
    .rd_i    (q_take),
    .vld_o   (q_vld),
    .rdata_o (q_op)
  );

  pfc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_vld_i       (q_vld),
    .op_i           (q_op),
    .take_o         (q_take),
    .pop            (pop),
    .empty          (empty),
    .handled_o      (handled_o),
    .access_error_o (access_error_o),
    .read_data_o    (read_data_o),
    .pixel_color_o  (pixel_color_o)
  );

  a_err_handled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && access_error_o |-> handled_o && read_data_o == 32'd0)
    else $error("error item without handled flag or with read data");

  a_bus_no_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && handled_o |-> pixel_color_o == 32'd0)
    else $error("bus item carries a pixel colour");

  a_take_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_take |-> q_vld)
    else $error("back end took from an empty queue");

  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> empty && !full)
    else $error("queues not empty after reset");

endmodule

// ===== tb/palette_framebuffer_controller_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette framebuffer controller core testbench
// Drives bus reads, bus writes and pixel conversions through the queue-style
// ports with random idling on both sides. A shadow of the window, control
// words and palette predicts every response, which is checked in order.
// ----------------------------------------------------------------------------
module palette_framebuffer_controller_core_test;

  localparam logic [1:0]  CMD_NONE    = 2'd3;
  localparam int          MAX_GAP     = 18;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          RANDOM_RUN  = 200;
  localparam logic [31:0] WIN_BYTES   = 32'(pfc_pkg::WINDOW_BYTES);

  typedef struct {
    logic [1:0]  command;
    logic [31:0] bus_address;
    logic [3:0]  access_size;
    logic [31:0] write_data;
    logic [31:0] pixel_word;
  } pfc_item_t;

  typedef struct {
    logic        handled;
    logic        access_error;
    logic [31:0] read_data;
    logic [31:0] pixel_color;
  } pfc_resp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  command_i = '0;
  logic [31:0] bus_address_i = '0;
  logic [3:0]  access_size_i = '0;
  logic [31:0] write_data_i = '0;
  logic [31:0] pixel_word_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic        handled_o;
  logic        access_error_o;
  logic [31:0] read_data_o;
  logic [31:0] pixel_color_o;

  logic [31:0] win_base;
  logic [31:0] ctrl_words [4];
  logic [31:0] palette_shadow [pfc_pkg::PALETTE_DEPTH];
  pfc_resp_t   owed_responses [$];
  int          error_count = 0;
  int          cycle_count = 0;
  bit          no_idle = 1'b0;

  palette_framebuffer_controller_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .push           (push),
    .full           (full),
    .command_i      (command_i),
    .bus_address_i  (bus_address_i),
    .access_size_i  (access_size_i),
    .write_data_i   (write_data_i),
    .pixel_word_i   (pixel_word_i),
    .empty          (empty),
    .pop            (pop),
    .handled_o      (handled_o),
    .access_error_o (access_error_o),
    .read_data_o    (read_data_o),
    .pixel_color_o  (pixel_color_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic pfc_resp_t controller_response(pfc_item_t it);
    pfc_resp_t                     r;
    logic [32:0]                   limit;
    logic [32:0]                   top;
    logic [31:0]                   off;
    logic [pfc_pkg::PAL_IDX_W-1:0] idx;
    logic [7:0]                    lo;
    r = '{default: '0};
    lo = it.pixel_word[7:0];
    if (it.command == pfc_pkg::CMD_PIXEL) begin
      if (ctrl_words[pfc_pkg::CTRL_MODE] == pfc_pkg::MODE_GREY) begin
        r.pixel_color = {lo, lo, lo, pfc_pkg::ALPHA_OPAQUE};
      end else if (ctrl_words[pfc_pkg::CTRL_MODE] == pfc_pkg::MODE_INDEXED) begin
        r.pixel_color = (lo < pfc_pkg::PALETTE_DEPTH) ? palette_shadow[lo] : 32'h0;
      end else begin
        r.pixel_color = it.pixel_word;
      end
    end else if (it.command == pfc_pkg::CMD_READ || it.command == pfc_pkg::CMD_WRITE) begin
      limit = {1'b0, win_base} + {1'b0, WIN_BYTES};
      top   = {1'b0, it.bus_address} + {29'b0, it.access_size};
      if (it.bus_address >= win_base && top <= limit) begin
        r.handled = 1'b1;
        if (it.access_size != pfc_pkg::WORD_BYTES || it.bus_address[1:0] != 2'b00) begin
          r.access_error = 1'b1;
        end else begin
          off = it.bus_address - win_base;
          if (off < 32'(pfc_pkg::CTRL_BYTES)) begin
            if (it.command == pfc_pkg::CMD_WRITE) ctrl_words[off[3:2]] = it.write_data;
            else r.read_data = ctrl_words[off[3:2]];
          end else begin
            idx = pfc_pkg::PAL_IDX_W'((off - 32'(pfc_pkg::CTRL_BYTES)) >> 2);
            if (it.command == pfc_pkg::CMD_WRITE) palette_shadow[idx] = it.write_data;
            else r.read_data = palette_shadow[idx];
          end
        end
      end
    end
    return r;
  endfunction

  function automatic pfc_item_t bus_item(logic [1:0] cmd, logic [31:0] addr,
                                         logic [3:0] size, logic [31:0] data);
    pfc_item_t it;
    it.command     = cmd;
    it.bus_address = addr;
    it.access_size = size;
    it.write_data  = data;
    it.pixel_word  = $urandom;
    return it;
  endfunction

  function automatic pfc_item_t pixel_item(logic [31:0] word);
    pfc_item_t it;
    it = bus_item(pfc_pkg::CMD_PIXEL, $urandom, 4'($urandom_range(0, 15)), $urandom);
    it.pixel_word = word;
    return it;
  endfunction

  function automatic pfc_item_t random_item(logic [31:0] base);
    pfc_item_t   it;
    int          roll;
    int          slot;
    logic [31:0] data;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      it = pixel_item($urandom);
    end else if (roll < 85) begin
      slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3)
                                         : $urandom_range(0, 3 + pfc_pkg::PALETTE_DEPTH);
      data = $urandom;
      if (slot == pfc_pkg::CTRL_MODE && $urandom_range(0, 3) != 0) data = $urandom_range(0, 2);
      it = bus_item($urandom_range(0, 1) ? pfc_pkg::CMD_WRITE : pfc_pkg::CMD_READ,
                    base + 32'(slot * 4), pfc_pkg::WORD_BYTES, data);
    end else begin
      it = bus_item(2'($urandom_range(0, 3)),
                    (roll < 93) ? base + $urandom_range(0, pfc_pkg::WINDOW_BYTES + 8) - 32'd4
                                : $urandom,
                    4'($urandom_range(0, 15)), $urandom);
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h", what, got, want);
    error_count++;
  endtask

  task automatic send_item(pfc_item_t it);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push          <= 1'b1;
    command_i     <= it.command;
    bus_address_i <= it.bus_address;
    access_size_i <= it.access_size;
    write_data_i  <= it.write_data;
    pixel_word_i  <= it.pixel_word;
    do @(posedge clk_i); while (full);
    owed_responses.push_back(controller_response(it));
  endtask

  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (owed_responses.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_window_base(logic [31:0] value);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    win_base = value;
  endtask

  task automatic test_reset_values();
    send_item(bus_item(pfc_pkg::CMD_READ, 32'h0, pfc_pkg::WORD_BYTES, $urandom));
    send_item(bus_item(pfc_pkg::CMD_READ, 32'h4, pfc_pkg::WORD_BYTES, $urandom));
    send_item(bus_item(pfc_pkg::CMD_READ, 32'h8, pfc_pkg::WORD_BYTES, $urandom));
    send_item(bus_item(pfc_pkg::CMD_READ, 32'h10, pfc_pkg::WORD_BYTES, $urandom));
    send_item(pixel_item(32'hFFFF_FF00));
  endtask

  task automatic test_control_words();
    send_item(bus_item(pfc_pkg::CMD_WRITE, 32'h0, pfc_pkg::WORD_BYTES, 32'hFFFF_FFFF));
    send_item(bus_item(pfc_pkg::CMD_WRITE, 32'hC, pfc_pkg::WORD_BYTES, 32'hA5A5_5A5A));
    send_item(bus_item(pfc_pkg::CMD_READ, 32'hC, pfc_pkg::WORD_BYTES, $urandom));
  endtask

  task automatic test_pixel_modes();
    send_item(bus_item(pfc_pkg::CMD_WRITE, 32'h10, pfc_pkg::WORD_BYTES, 32'hFFFF_FFFF));
    send_item(bus_item(pfc_pkg::CMD_WRITE, WIN_BYTES - 32'd4, pfc_pkg::WORD_BYTES,
                       32'h1234_5678));
    send_item(pixel_item(32'h0000_00FF));
    send_item(bus_item(pfc_pkg::CMD_WRITE, 32'h4, pfc_pkg::WORD_BYTES, pfc_pkg::MODE_INDEXED));
    send_item(pixel_item(32'hFFFF_FF00));
    send_item(pixel_item(32'hFFFF_FFFF));
    send_item(bus_item(pfc_pkg::CMD_WRITE, 32'h4, pfc_pkg::WORD_BYTES, 32'd2));
    send_item(pixel_item(32'h5AC3_3CA5));
    send_item(bus_item(pfc_pkg::CMD_WRITE, 32'h4, pfc_pkg::WORD_BYTES, 32'hFFFF_FFFF));
    send_item(pixel_item(32'hFFFF_FFFF));
  endtask

  task automatic test_bad_accesses();
    set_window_base(32'h0000_1000);
    send_item(bus_item(pfc_pkg::CMD_READ, 32'h1002, pfc_pkg::WORD_BYTES, $urandom));
    send_item(bus_item(pfc_pkg::CMD_WRITE, 32'h1000, 4'd2, $urandom));
    send_item(bus_item(pfc_pkg::CMD_READ, 32'h1010, 4'd8, $urandom));
    send_item(bus_item(pfc_pkg::CMD_WRITE, 32'h1020, 4'd0, $urandom));
    send_item(bus_item(pfc_pkg::CMD_READ, 32'h0FFC, pfc_pkg::WORD_BYTES, $urandom));
    send_item(bus_item(pfc_pkg::CMD_READ, 32'h1000 + WIN_BYTES - 32'd4,
                       pfc_pkg::WORD_BYTES, $urandom));
    send_item(bus_item(pfc_pkg::CMD_WRITE, 32'h1000 + WIN_BYTES - 32'd2,
                       pfc_pkg::WORD_BYTES, $urandom));
    send_item(bus_item(CMD_NONE, 32'hFFFF_FFFF, 4'hF, 32'hFFFF_FFFF));
  endtask

  task automatic test_random_traffic();
    logic [31:0] bases [6];
    bases = '{32'hFFFF_FFFF, 32'hFFFF_FFFF - WIN_BYTES + 32'd1, 32'h0,
              $urandom, $urandom & ~32'h3, 32'h7FFF_FFFE};
    foreach (bases[b]) begin
      set_window_base(bases[b]);
      for (int n = 0; n < RANDOM_RUN; n++) begin
        no_idle = ((n / 50) % 2) == 1;
        send_item(random_item(win_base));
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin : response_check
    pfc_resp_t want;
    int        stall;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        pop <= 1'b0;
        stall--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk_i);
      if (pop && !empty) begin
        if (owed_responses.size() == 0) begin
          report_mismatch("result with none owed", read_data_o, 32'h0);
        end else begin
          want = owed_responses.pop_front();
          if (handled_o !== want.handled)
            report_mismatch("handled", {31'd0, handled_o}, {31'd0, want.handled});
          if (access_error_o !== want.access_error)
            report_mismatch("access_error", {31'd0, access_error_o},
                            {31'd0, want.access_error});
          if (read_data_o !== want.read_data)
            report_mismatch("read_data", read_data_o, want.read_data);
          if (pixel_color_o !== want.pixel_color)
            report_mismatch("pixel_color", pixel_color_o, want.pixel_color);
        end
        stall = draw_gap();
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : sequencer
    win_base = '0;
    foreach (ctrl_words[i]) ctrl_words[i] = '0;
    foreach (palette_shadow[i]) palette_shadow[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_control_words();
    test_pixel_modes();
    test_bad_accesses();
    test_random_traffic();
    drain();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
